// ===== hdl/mm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg: shared definitions for the matrix multiplier
// Field widths, register map, and the command and status groups that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int ELEM_BITS   = 16;
    localparam int ACC_BITS    = 32;
    localparam int PROD_BITS   = 2 * ELEM_BITS;
    localparam int OUT_BITS    = 32;
    localparam int POS_BITS    = 3;
    localparam int CFG_BITS    = 4;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 4;

    localparam logic [CFG_BITS-1:0] DIM_RESET = 4'd8;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_ROWS_M  = 2'd0;
    localparam logic [1:0] REG_INNER_N = 2'd1;
    localparam logic [1:0] REG_COLS_P  = 2'd2;

    typedef struct packed {
        logic load;         // input item accepted this cycle
        logic issue;        // read one A/B pair for the current entry
        logic first;        // pair opens a dot product
        logic last;         // pair closes a dot product
        logic final_entry;  // entry is the last one of the product
    } mm_cmd_t;

    typedef struct packed {
        logic complete;     // accepted item finishes both matrices
        logic out_taken;    // result item handed over this cycle
    } mm_status_t;

endpackage
`default_nettype wire

// ===== hdl/mm_stream_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm stream interfaces
// Valid/ready channels for matrix elements in and product entries out.
// ----------------------------------------------------------------------------
interface mm_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [mm_pkg::ELEM_BITS-1:0] elem_value;
    logic                                to_b;

    modport source (output valid, elem_value, to_b, input ready);
    modport sink   (input valid, elem_value, to_b, output ready);
endinterface

interface mm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [mm_pkg::OUT_BITS-1:0] product_value;
    logic        [mm_pkg::POS_BITS-1:0] out_row;
    logic        [mm_pkg::POS_BITS-1:0] out_col;
    logic                               last_entry;

    modport source (output valid, product_value, out_row, out_col, last_entry, input ready);
    modport sink   (input valid, product_value, out_row, out_col, last_entry, output ready);
endinterface
`default_nettype wire

// ===== hdl/mm_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_regs: configuration registers
// APB register file for the three matrix sizes, with clamping to 1..MAX_DIM.
// ----------------------------------------------------------------------------
module mm_regs #(
    parameter  int MAX_DIM = mm_pkg::MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mm_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    output logic      [DIM_W-1:0]              dim_m,
    output logic      [DIM_W-1:0]              dim_n,
    output logic      [DIM_W-1:0]              dim_p
);

    logic [mm_pkg::CFG_BITS-1:0] rows_m_reg;
    logic [mm_pkg::CFG_BITS-1:0] inner_n_reg;
    logic [mm_pkg::CFG_BITS-1:0] cols_p_reg;
    logic [1:0]                  reg_idx;
    logic                        wr_en;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [mm_pkg::CFG_BITS-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (32'(v) > MAX_DIM)
            r = DIM_W'(MAX_DIM);
        else
            r = DIM_W'(v);
        return r;
    endfunction

    assign reg_idx = paddr[mm_pkg::APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_m_reg  <= mm_pkg::DIM_RESET;
            inner_n_reg <= mm_pkg::DIM_RESET;
            cols_p_reg  <= mm_pkg::DIM_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                mm_pkg::REG_ROWS_M:  rows_m_reg  <= pwdata[mm_pkg::CFG_BITS-1:0];
                mm_pkg::REG_INNER_N: inner_n_reg <= pwdata[mm_pkg::CFG_BITS-1:0];
                mm_pkg::REG_COLS_P:  cols_p_reg  <= pwdata[mm_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mm_pkg::REG_ROWS_M:  prdata = mm_pkg::APB_DATA_W'(rows_m_reg);
            mm_pkg::REG_INNER_N: prdata = mm_pkg::APB_DATA_W'(inner_n_reg);
            mm_pkg::REG_COLS_P:  prdata = mm_pkg::APB_DATA_W'(cols_p_reg);
            default:             prdata = '0;
        endcase
    end

    assign dim_m = clamp_dim(rows_m_reg);
    assign dim_n = clamp_dim(inner_n_reg);
    assign dim_p = clamp_dim(cols_p_reg);

endmodule
`default_nettype wire

// ===== hdl/mm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_ctrl: sequencing controller
// Takes elements while loading, then walks row, column and inner index,
// issuing one operand pair a cycle and waiting for each entry to be taken.
// ----------------------------------------------------------------------------
module mm_ctrl #(
    parameter  int MAX_DIM = mm_pkg::MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int IDX_W   = $clog2(MAX_DIM)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DIM_W-1:0]   dim_m,
    input  wire logic [DIM_W-1:0]   dim_n,
    input  wire logic [DIM_W-1:0]   dim_p,
    input  wire mm_pkg::mm_status_t status,
    output mm_pkg::mm_cmd_t         cmd,
    output logic      [IDX_W-1:0]   row_idx,
    output logic      [IDX_W-1:0]   col_idx,
    output logic      [IDX_W-1:0]   inner_idx
);

    typedef enum logic [2:0] {
        S_LOAD = 3'b001,
        S_RUN  = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] k_reg, k_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic             last_i, last_k, last_j;

    assign last_i = (DIM_W'(i_reg) + DIM_W'(1)) == dim_m;
    assign last_k = (DIM_W'(k_reg) + DIM_W'(1)) == dim_p;
    assign last_j = (DIM_W'(j_reg) + DIM_W'(1)) == dim_n;

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        in_ready        = 1'b0;
        cmd             = '0;
        cmd.first       = (j_reg == '0);
        cmd.last        = last_j;
        cmd.final_entry = last_i && last_k;
        unique case (state_reg)
            S_LOAD:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid && status.complete)
                begin
                    state_next = S_RUN;
                    i_next     = '0;
                    k_next     = '0;
                    j_next     = '0;
                end
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (last_j)
                begin
                    j_next     = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_OUT:
            begin
                // hold until the entry is taken, then advance column, then row
                if (status.out_taken)
                begin
                    state_next = S_RUN;
                    if (last_k)
                    begin
                        k_next = '0;
                        if (last_i)
                        begin
                            i_next     = '0;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            i_reg     <= '0;
            k_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
            j_reg     <= j_next;
        end
    end

    assign row_idx   = i_reg;
    assign col_idx   = k_reg;
    assign inner_idx = j_reg;

endmodule
`default_nettype wire

// ===== hdl/mm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mm_datapath: operand stores and multiply-accumulate pipeline
// Holds A and B in two memories with load counts, reads one operand pair a
// cycle, multiplies, accumulates and keeps the finished entry in an output
// register.
// ----------------------------------------------------------------------------
module mm_datapath #(
    parameter  int MAX_DIM = mm_pkg::MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int IDX_W   = $clog2(MAX_DIM)
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire mm_pkg::mm_cmd_t                     cmd,
    output mm_pkg::mm_status_t                       status,
    input  wire logic        [DIM_W-1:0]             dim_m,
    input  wire logic        [DIM_W-1:0]             dim_n,
    input  wire logic        [DIM_W-1:0]             dim_p,
    input  wire logic        [IDX_W-1:0]             row_idx,
    input  wire logic        [IDX_W-1:0]             col_idx,
    input  wire logic        [IDX_W-1:0]             inner_idx,
    input  wire logic signed [mm_pkg::ELEM_BITS-1:0] elem_value,
    input  wire logic                                to_b,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed      [mm_pkg::OUT_BITS-1:0]  product_value,
    output logic             [mm_pkg::POS_BITS-1:0]  out_row,
    output logic             [mm_pkg::POS_BITS-1:0]  out_col,
    output logic                                     last_entry
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic signed [mm_pkg::ELEM_BITS-1:0] a_mem [DEPTH];
    logic signed [mm_pkg::ELEM_BITS-1:0] b_mem [DEPTH];

    logic [CNT_W-1:0] a_cnt_reg, a_cnt_next, a_cnt_inc;
    logic [CNT_W-1:0] b_cnt_reg, b_cnt_next, b_cnt_inc;
    logic [CNT_W-1:0] a_size, b_size;
    logic             wr_a, wr_b;
    logic [CNT_W-1:0] a_rd_full, b_rd_full;

    logic                                s1_valid_reg;
    logic                                s1_first_reg, s1_last_reg, s1_final_reg;
    logic [IDX_W-1:0]                    s1_row_reg, s1_col_reg;
    logic signed [mm_pkg::ELEM_BITS-1:0] a_rd_reg, b_rd_reg;

    logic                                s2_valid_reg;
    logic                                s2_first_reg, s2_last_reg, s2_final_reg;
    logic [IDX_W-1:0]                    s2_row_reg, s2_col_reg;
    logic signed [mm_pkg::PROD_BITS-1:0] prod_reg;

    logic signed [mm_pkg::ACC_BITS-1:0]  acc_reg, acc_sum;
    logic                                out_valid_reg;
    logic signed [mm_pkg::ACC_BITS-1:0]  out_value_reg;
    logic [IDX_W-1:0]                    out_row_reg, out_col_reg;
    logic                                out_last_reg;

    // load counting; an element for a full store is dropped
    assign a_size    = CNT_W'(dim_m) * CNT_W'(dim_n);
    assign b_size    = CNT_W'(dim_n) * CNT_W'(dim_p);
    assign wr_a      = cmd.load && !to_b && (a_cnt_reg < a_size);
    assign wr_b      = cmd.load && to_b && (b_cnt_reg < b_size);
    assign a_cnt_inc = a_cnt_reg + CNT_W'(wr_a);
    assign b_cnt_inc = b_cnt_reg + CNT_W'(wr_b);

    assign status.complete  = (a_cnt_inc >= a_size) && (b_cnt_inc >= b_size);
    assign status.out_taken = out_valid_reg && out_ready;

    always_comb
    begin
        a_cnt_next = a_cnt_reg;
        b_cnt_next = b_cnt_reg;
        if (cmd.load)
        begin
            a_cnt_next = status.complete ? '0 : a_cnt_inc;
            b_cnt_next = status.complete ? '0 : b_cnt_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_cnt_reg <= '0;
            b_cnt_reg <= '0;
        end
        else
        begin
            a_cnt_reg <= a_cnt_next;
            b_cnt_reg <= b_cnt_next;
        end
    end

    // A at i*n + j, B at j*p + k
    assign a_rd_full = CNT_W'(row_idx) * CNT_W'(dim_n) + CNT_W'(inner_idx);
    assign b_rd_full = CNT_W'(inner_idx) * CNT_W'(dim_p) + CNT_W'(col_idx);

    always_ff @(posedge clk)
    begin
        if (wr_a)
            a_mem[a_cnt_reg[AW-1:0]] <= elem_value;
        if (wr_b)
            b_mem[b_cnt_reg[AW-1:0]] <= elem_value;
        a_rd_reg <= a_mem[a_rd_full[AW-1:0]];
        b_rd_reg <= b_mem[b_rd_full[AW-1:0]];
    end

    assign acc_sum = (s2_first_reg ? '0 : acc_reg) + mm_pkg::ACC_BITS'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            if (s2_valid_reg && s2_last_reg)
                out_valid_reg <= 1'b1;
            else if (status.out_taken)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last;
        s1_final_reg <= cmd.final_entry;
        s1_row_reg   <= row_idx;
        s1_col_reg   <= col_idx;

        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_final_reg <= s1_final_reg;
        s2_row_reg   <= s1_row_reg;
        s2_col_reg   <= s1_col_reg;
        prod_reg     <= a_rd_reg * b_rd_reg;

        if (s2_valid_reg)
            acc_reg <= acc_sum;
        if (s2_valid_reg && s2_last_reg)
        begin
            out_value_reg <= acc_sum;
            out_row_reg   <= s2_row_reg;
            out_col_reg   <= s2_col_reg;
            out_last_reg  <= s2_final_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign product_value = mm_pkg::OUT_BITS'(out_value_reg);
    assign out_row       = mm_pkg::POS_BITS'(out_row_reg);
    assign out_col       = mm_pkg::POS_BITS'(out_col_reg);
    assign last_entry    = out_last_reg;

endmodule
`default_nettype wire

// ===== hdl/matrix_multiply.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply: streamed general matrix multiply
// Loads A (M x N) and B (N x P) per element, as to_b selects; emits A*B row-major.
// ----------------------------------------------------------------------------
// Loading takes one element item per cycle; input is held off while computing.
// Each product entry is built from N operand reads, one pair at a time
// from the single read port of each store, then multiply and accumulate.
// The first entry passes the operand read, product and output registers.
// Reset sets all three sizes to 8 and clears both load counts; the operand
// stores hold no reset value, and a product uses them only after loading.
module matrix_multiply #(
    parameter  int MAX_DIM = mm_pkg::MAX_DIM_DEF,
    localparam int DIM_W   = $clog2(MAX_DIM + 1),
    localparam int IDX_W   = $clog2(MAX_DIM)
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mm_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [mm_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [mm_pkg::APB_DATA_W-1:0] prdata,
    output logic                               pready,
    mm_in_if.sink                              in_ch,
    mm_out_if.source                           out_ch
);

    logic [DIM_W-1:0]   dim_m, dim_n, dim_p;
    logic [IDX_W-1:0]   row_idx, col_idx, inner_idx;
    mm_pkg::mm_cmd_t    cmd;
    mm_pkg::mm_status_t status;
    logic               in_ready;
    logic               out_valid;
    logic signed [mm_pkg::OUT_BITS-1:0] product_value;
    logic        [mm_pkg::POS_BITS-1:0] out_row, out_col;
    logic                               last_entry;

    mm_regs #(.MAX_DIM(MAX_DIM)) u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .dim_m   (dim_m),
        .dim_n   (dim_n),
        .dim_p   (dim_p)
    );

    mm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ready),
        .dim_m     (dim_m),
        .dim_n     (dim_n),
        .dim_p     (dim_p),
        .status    (status),
        .cmd       (cmd),
        .row_idx   (row_idx),
        .col_idx   (col_idx),
        .inner_idx (inner_idx)
    );

    mm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .dim_m         (dim_m),
        .dim_n         (dim_n),
        .dim_p         (dim_p),
        .row_idx       (row_idx),
        .col_idx       (col_idx),
        .inner_idx     (inner_idx),
        .elem_value    (in_ch.elem_value),
        .to_b          (in_ch.to_b),
        .out_valid     (out_valid),
        .out_ready     (out_ch.ready),
        .product_value (product_value),
        .out_row       (out_row),
        .out_col       (out_col),
        .last_entry    (last_entry)
    );

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = out_valid;
    assign out_ch.product_value = product_value;
    assign out_ch.out_row       = out_row;
    assign out_ch.out_col       = out_col;
    assign out_ch.last_entry    = last_entry;

endmodule
`default_nettype wire
